FILE: src/bra_pkg.sv
// Package for the bit map run allocator: word geometry and operation codes.
// No dependencies.
package bra_pkg;

    localparam int WORD_W     = 32;
    localparam int WORD_BIT_W = 5;
    localparam int CHUNK_W    = 8;
    localparam int CHUNK_BIT_W = 3;
    localparam int NCHUNK     = WORD_W / CHUNK_W;
    localparam int CHUNK_IDX_W = 2;

    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_ALLOC = 2'd3;

    typedef struct packed {
        logic       success;
        logic [9:0] found_index;
        logic       read_bit;
    } bra_result_t;

endpackage

FILE: src/bra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

FILE: src/bitmap_run_allocator_unit.sv
// Top level of the bit map run allocator: sequencer around one word-wide RAM.
// Depends on bra_pkg and bra_ram.
//
// Usage:
//   One register, total_bits, written through cfg_wr_en / cfg_wr_data while
//   the block is idle. Requests arrive on the s_ channel (valid/ready); each
//   request yields exactly one result transaction on the m_ channel.
//   The map lives in a RAM of 32-bit words (MAX_BITS/32 words, rounded up); every
//   operation walks that RAM one word access at a time.
//   Steps per request, each followed by a result step:
//     fill all      : one write per word
//     set range     : a read and a write-back per touched word
//     query         : a read of the word that holds the bit
//     allocate      : scan reads 8 bits a cycle within a word, after a read
//                     step per word, then a read and a write-back per word of the found run
//   The scan rate is set by the 8-step run counter chain per cycle.
//   After reset the RAM is cleared one word at a time, during which s_ready is low.
//   A finished result sits in the output register; a stalled receiver holds the next
//   result in its staging register, and no new request is taken, until m_ready frees it.
module bitmap_run_allocator_unit
    import bra_pkg::*;
#(
    parameter int MAX_BITS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [9:0]  s_start_index,
    input  logic [10:0] s_run_length,
    input  logic        s_bit_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic [9:0]  m_found_index,
    output logic        m_read_bit
);
    localparam int NUM_WORDS = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int AW = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int PW = $clog2(MAX_BITS) + 1;
    localparam int CW = (PW > 12 ? PW : 12) + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_QRY  = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SCAN = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [AW-1:0]          word_reg, word_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg, chunk_next;
    logic [CW-1:0]          run_reg, run_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [10:0]            len_reg, len_next;
    logic                   val_reg, val_next;
    logic [10:0]            total_bits_reg;
    bra_result_t            res_reg, res_next;
    bra_result_t            out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [WORD_W-1:0]      ram_wdata, ram_rdata;

    logic [CW-1:0]          used;
    logic [CW-1:0]          set_hi;
    logic [WORD_W-1:0]      merged;
    logic                   scan_hit, scan_end;
    logic [CW-1:0]          scan_pos, scan_run;
    logic [CW-1:0]          word_base;
    logic [CW-1:0]          run_start;

    bra_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Bits in use: clamp the register to the map size.
    assign used = (CW'(total_bits_reg) < CW'(MAX_BITS)) ? CW'(total_bits_reg) : CW'(MAX_BITS);

    always_comb begin
        logic [CW-1:0] sum;
        sum = CW'(s_start_index) + CW'(s_run_length);
        set_hi = (sum < used) ? sum : used;
    end

    assign word_base = CW'({word_reg, WORD_BIT_W'(0)});

    // Read-modify-write merge: replace bits inside [lo, hi).
    always_comb begin
        logic [CW-1:0] pos;
        for (int k = 0; k < WORD_W; k++) begin
            pos = word_base + CW'(k);
            merged[k] = (pos >= lo_reg && pos < hi_reg) ? val_reg : ram_rdata[k];
        end
    end

    // Run counter over one 8-bit chunk of the held word.
    always_comb begin
        logic [CW-1:0] pos;
        logic [CW-1:0] run;
        logic          b;
        run      = run_reg;
        scan_hit = 1'b0;
        scan_end = 1'b0;
        scan_pos = '0;
        for (int k = 0; k < CHUNK_W; k++) begin
            pos = CW'({word_reg, chunk_reg, CHUNK_BIT_W'(k)});
            b   = ram_rdata[{chunk_reg, CHUNK_BIT_W'(k)}];
            if (!scan_hit && !scan_end) begin
                if (pos >= used) begin
                    scan_end = 1'b1;
                end else begin
                    run = (b == val_reg) ? run + CW'(1) : '0;
                    if (run == CW'(len_reg)) begin
                        scan_hit = 1'b1;
                        scan_pos = pos;
                    end
                end
            end
        end
        scan_run = run;
    end

    assign run_start = scan_pos + CW'(1) - CW'(len_reg);

    always_comb begin
        state_next   = state_reg;
        word_next    = word_reg;
        chunk_next   = chunk_reg;
        run_next     = run_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        len_next     = len_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = word_reg;
        ram_raddr    = word_reg;
        ram_wdata    = merged;
        s_ready      = 1'b0;

        // Drop the output transaction once taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                word_next = word_reg + AW'(1);
                if (word_reg == AW'(NUM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    val_next = s_bit_value;
                    len_next = s_run_length;
                    lo_next  = CW'(s_start_index);
                    hi_next  = set_hi;
                    res_next = '{success: 1'b1, found_index: '0, read_bit: 1'b0};
                    word_next  = '0;
                    chunk_next = '0;
                    run_next   = '0;
                    unique case (s_operation)
                        OP_FILL: state_next = S_FILL;
                        OP_SET: begin
                            if (CW'(s_start_index) < set_hi) begin
                                word_next  = s_start_index[AW+WORD_BIT_W-1:WORD_BIT_W];
                                state_next = S_RD;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        OP_QUERY: begin
                            if (CW'(s_start_index) < used) begin
                                ram_re     = 1'b1;
                                ram_raddr  = s_start_index[AW+WORD_BIT_W-1:WORD_BIT_W];
                                state_next = S_QRY;
                            end else begin
                                res_next.success = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            if (s_run_length != 11'd0 && CW'(s_run_length) <= used) begin
                                state_next = S_SRD;
                            end else begin
                                res_next.success = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = {WORD_W{val_reg}};
                word_next = word_reg + AW'(1);
                if (word_reg == AW'(NUM_WORDS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                ram_we = 1'b1;
                if (word_base + CW'(WORD_W) >= hi_reg) begin
                    state_next = S_DONE;
                end else begin
                    word_next  = word_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_QRY: begin
                res_next.read_bit = ram_rdata[lo_reg[WORD_BIT_W-1:0]];
                state_next = S_DONE;
            end
            S_SRD: begin
                ram_re     = 1'b1;
                chunk_next = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                run_next = scan_run;
                if (scan_hit) begin
                    // Invert the found run through the read-modify-write path.
                    lo_next  = run_start;
                    hi_next  = scan_pos + CW'(1);
                    val_next = ~val_reg;
                    res_next.found_index = run_start[9:0];
                    word_next  = run_start[AW+WORD_BIT_W-1:WORD_BIT_W];
                    state_next = S_RD;
                end else if (scan_end || (word_reg == AW'(NUM_WORDS - 1) &&
                                          chunk_reg == CHUNK_IDX_W'(NCHUNK - 1))) begin
                    res_next.success = 1'b0;
                    state_next = S_DONE;
                end else if (chunk_reg == CHUNK_IDX_W'(NCHUNK - 1)) begin
                    word_next  = word_reg + AW'(1);
                    state_next = S_SRD;
                end else begin
                    chunk_next = chunk_reg + CHUNK_IDX_W'(1);
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up.
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            word_reg       <= '0;
            m_valid_reg    <= 1'b0;
            total_bits_reg <= 11'd1024;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                total_bits_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chunk_reg <= chunk_next;
        run_reg   <= run_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        len_reg   <= len_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_success     = out_reg.success;
    assign m_found_index = out_reg.found_index;
    assign m_read_bit    = out_reg.read_bit;

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("RAM read and write in one cycle");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while busy");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR) |-> (word_base < hi_reg))
        else $error("write-back word beyond range end");

    a_run_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (run_reg < CW'(len_reg)))
        else $error("run count reached length without a hit");
endmodule

FILE: verif/bitmap_run_allocator_unit_test.sv
// Self-checking testbench for bitmap_run_allocator_unit: directed and random requests,
// predicted against a behavioral copy of the bit map, with random idling on both sides.
// Depends on bra_pkg and the RTL of bitmap_run_allocator_unit.
module bitmap_run_allocator_unit_test;
    import bra_pkg::*;

    localparam int MAP_BITS = 1024;

    typedef struct packed {
        logic       success;
        logic [9:0] found_index;
        logic       read_bit;
    } alloc_answer_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [9:0]  s_start_index;
    logic [10:0] s_run_length;
    logic        s_bit_value;
    logic        m_valid;
    logic        m_ready;
    logic        m_success;
    logic [9:0]  m_found_index;
    logic        m_read_bit;

    // Shadow copy of the map and of the size register
    logic        shadow_map [MAP_BITS];
    logic [10:0] shadow_total;
    alloc_answer_t pending_answers[$];
    int          error_count;

    // Idle percentages (0..100), changed per phase
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    bitmap_run_allocator_unit #(.MAX_BITS(MAP_BITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_start_index (s_start_index),
        .s_run_length  (s_run_length),
        .s_bit_value   (s_bit_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_found_index (m_found_index),
        .m_read_bit    (m_read_bit)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Apply one request to the shadow map and return the answer it produces.
    function automatic alloc_answer_t predict_answer(logic [1:0] op, logic [9:0] start,
                                                     logic [10:0] len, logic val);
        alloc_answer_t ans;
        int used;
        int run;
        ans = '0;
        used = (shadow_total < MAP_BITS) ? shadow_total : MAP_BITS;
        run = 0;
        case (op)
            OP_FILL: begin
                foreach (shadow_map[i]) shadow_map[i] = val;
                ans.success = 1'b1;
            end
            OP_SET: begin
                for (int i = 0; i < len && start + i < used; i++)
                    shadow_map[start + i] = val;
                ans.success = 1'b1;
            end
            OP_QUERY: begin
                if (start < used) begin
                    ans.success  = 1'b1;
                    ans.read_bit = shadow_map[start];
                end
            end
            default: begin
                if (len != 0 && len <= used) begin
                    for (int i = 0; i < used; i++) begin
                        if (shadow_map[i] == val) begin
                            run++;
                            if (run == len) begin
                                for (int k = i + 1 - len; k <= i; k++)
                                    shadow_map[k] = ~val;
                                ans.success     = 1'b1;
                                ans.found_index = 10'(i + 1 - len);
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
            end
        endcase
        return ans;
    endfunction

    // Offer one transaction, hold it until accepted, then log the prediction.
    // Valid stays high after acceptance; the next request or an idle stretch replaces it.
    task automatic send_request(logic [1:0] op, logic [9:0] start, logic [10:0] len,
                                logic val);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_start_index <= start;
        s_run_length  <= len;
        s_bit_value   <= val;
        do @(posedge aclk); while (!s_ready);
        pending_answers.push_back(predict_answer(op, start, len, val));
    endtask

    // Drop valid at the next falling edge once the last request is taken.
    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Wait for every answer, let the block settle, then write the size register.
    task automatic write_total(logic [10:0] total);
        release_input();
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= total;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        shadow_total = total;
    endtask

    // Receiver stall pattern; a hold-off request blocks it for a counted stretch.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                alloc_answer_t exp_ans;
                exp_ans = pending_answers.pop_front();
                if (m_success !== exp_ans.success) begin
                    $error("success: expected %0d actual %0d", exp_ans.success, m_success);
                    error_count++;
                end
                if (m_found_index !== exp_ans.found_index) begin
                    $error("found_index: expected %0d actual %0d",
                           exp_ans.found_index, m_found_index);
                    error_count++;
                end
                if (m_read_bit !== exp_ans.read_bit) begin
                    $error("read_bit: expected %0d actual %0d", exp_ans.read_bit, m_read_bit);
                    error_count++;
                end
            end
        end
    end

    // Directed corners: extremes of every field, each operation, each special case.
    task automatic test_directed();
        send_request(OP_QUERY, 10'd0, 11'd0, 1'b0);
        send_request(OP_QUERY, 10'd1023, 11'd0, 1'b1);
        send_request(OP_ALLOC, 10'd0, 11'd0, 1'b0);      // zero length fails
        send_request(OP_ALLOC, 10'd0, 11'd1024, 1'b0);   // whole map
        send_request(OP_QUERY, 10'd1023, 11'd0, 1'b0);
        send_request(OP_ALLOC, 10'd0, 11'd1, 1'b0);      // no fitting run
        send_request(OP_FILL, 10'd1023, 11'd2047, 1'b0);
        send_request(OP_SET, 10'd1020, 11'd2047, 1'b1);  // clipped at the end
        send_request(OP_QUERY, 10'd1023, 11'd0, 1'b0);
        send_request(OP_ALLOC, 10'd0, 11'd4, 1'b1);
        send_request(OP_ALLOC, 10'd0, 11'd1021, 1'b0);
        send_request(OP_ALLOC, 10'd0, 11'd1020, 1'b0);
        send_request(OP_SET, 10'd5, 11'd0, 1'b0);        // empty range
        send_request(OP_FILL, 10'd0, 11'd0, 1'b1);
        send_request(OP_ALLOC, 10'd0, 11'd1025, 1'b1);   // longer than the map
        send_request(OP_SET, 10'd512, 11'd3, 1'b0);
        send_request(OP_ALLOC, 10'd0, 11'd3, 1'b0);
        send_request(OP_QUERY, 10'd513, 11'd0, 1'b0);
    endtask

    // Several map sizes: small ones, an empty map, the size just past the map end and the largest field value.
    task automatic test_sizes();
        logic [10:0] sizes[6] = '{11'd0, 11'd1, 11'd37, 11'd2047, 11'd1025, 11'd8};
        foreach (sizes[n]) begin
            write_total(sizes[n]);
            send_request(OP_QUERY, 10'd0, 11'd0, 1'b0);
            send_request(OP_SET, 10'd2, 11'd100, 1'b1);
            send_request(OP_ALLOC, 10'd0, 11'd1, 1'b0);
            send_request(OP_ALLOC, 10'd0, sizes[n], 1'b0);
            send_request(OP_QUERY, 10'(sizes[n]), 11'd0, 1'b1);
            send_request(OP_QUERY, 10'd1023, 11'd0, 1'b1);
            for (int i = 0; i < 6; i++)
                send_request(2'($urandom_range(3)), 10'($urandom_range(40)),
                             11'($urandom_range(12)), 1'($urandom));
        end
    endtask

    // Random traffic: allocate-heavy with short runs, occasional long runs and fills.
    task automatic test_random(int count);
        logic [1:0]  op;
        logic [10:0] len;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       op = OP_FILL;
                1, 2:    op = OP_SET;
                3, 4:    op = OP_QUERY;
                default: op = OP_ALLOC;
            endcase
            len = ($urandom_range(19) == 0) ? 11'($urandom_range(2047))
                                            : 11'($urandom_range(40));
            send_request(op, 10'($urandom), len, 1'($urandom));
        end
    endtask

    // Long receiver hold-off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_request(OP_QUERY, 10'($urandom), 11'd0, 1'b0);
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_valid         = 1'b0;
        s_operation     = OP_FILL;
        s_start_index   = '0;
        s_run_length    = '0;
        s_bit_value     = 1'b0;
        m_ready         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        error_count     = 0;
        shadow_total    = 11'd1024;
        foreach (shadow_map[i]) shadow_map[i] = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_sizes();
        write_total(11'd1024);
        test_random(200);
        send_idle_pct = 73;
        test_random(200);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        test_random(200);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        write_total(11'd300);
        test_random(200);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        release_input();

        // Drain outstanding answers, then allow the pipeline to settle.
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("bitmap_run_allocator_unit_test OK");
        else
            $display("bitmap_run_allocator_unit_test NOT OK");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20000000;
        $display("bitmap_run_allocator_unit_test NOT OK");
        $finish;
    end

endmodule
